@@ sv/mlr_pkg.sv @@
// Shared widths, pipeline stage type and limiter codes for the MUSCL reconstruction block.
`default_nettype none
package mlr_pkg;

    localparam int DATA_W = 32;            // Q16.16 sample width
    localparam int DIFF_W = DATA_W + 1;    // signed slope between two cells
    localparam int MAG_W  = DATA_W;        // slope magnitude (never reaches 2^32)
    localparam int PROD_W = 2 * MAG_W;     // A*B
    localparam int DIV_W  = MAG_W + 1;     // divisor A+B, quotient, remainder
    localparam int MODE_W = 2;

    typedef enum logic [MODE_W-1:0] {
        LIM_MINMOD  = 2'd0,
        LIM_VANLEER = 2'd1,
        LIM_MC      = 2'd2
    } limiter_mode_t;

    // One slope in flight through the van Leer divider.
    typedef struct packed {
        logic              valid;
        logic              zero;   // slopes differ in sign or one is zero
        logic              neg;    // sign of the first slope
        logic [MAG_W-1:0]  alt;    // minmod or MC magnitude
        logic [DATA_W-1:0] base;   // cell value the half slope is applied to
        logic [DIV_W-1:0]  rem;    // partial remainder
        logic [DIV_W-1:0]  low;    // dividend bits still to shift in, MSB first
        logic [DIV_W-1:0]  quo;    // quotient bits so far
        logic [DIV_W-1:0]  dvs;    // divisor A+B
    } div_t;

endpackage
`default_nettype wire

@@ sv/mlr_div_step.sv @@
// One registered restoring-division step: one quotient bit per stage.
`default_nettype none
module mlr_div_step (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire mlr_pkg::div_t d_in,
    output mlr_pkg::div_t     d_out
);
    import mlr_pkg::*;

    div_t             d_next;
    div_t             d_reg;
    logic [DIV_W:0]   rem2;
    logic             ge;

    always_comb begin
        rem2   = {d_in.rem, d_in.low[DIV_W-1]};
        ge     = rem2 >= {1'b0, d_in.dvs};
        d_next = d_in;
        d_next.rem = ge ? DIV_W'(rem2 - {1'b0, d_in.dvs}) : rem2[DIV_W-1:0];
        d_next.low = {d_in.low[DIV_W-2:0], 1'b0};
        d_next.quo = {d_in.quo[DIV_W-2:0], ge};
    end

    // valid bit has no reset here; the owner resets the valid at the chain head and it shifts down from there
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

@@ sv/mlr_slope_unit.sv @@
// One limited slope: magnitudes, multiply, van Leer divider chain, half slope and saturation.
`default_nettype none
module mlr_slope_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic [mlr_pkg::MODE_W-1:0]  mode,
    input  wire logic                        negate,   // 1: base - half slope
    input  wire logic                        in_valid,
    input  wire logic [mlr_pkg::DIFF_W-1:0]  slope_a,
    input  wire logic [mlr_pkg::DIFF_W-1:0]  slope_b,
    input  wire logic [mlr_pkg::DATA_W-1:0]  base,
    output logic                             out_valid,
    output logic [mlr_pkg::DATA_W-1:0]       face
);
    import mlr_pkg::*;

    // ---- stage P0: sign test, magnitudes, minmod / MC ----
    logic              p0_valid_reg, p0_valid_next;
    logic              p0_zero_reg, p0_zero_next;
    logic              p0_neg_reg, p0_neg_next;
    logic [MAG_W-1:0]  p0_ma_reg, p0_ma_next;
    logic [MAG_W-1:0]  p0_mb_reg, p0_mb_next;
    logic [MAG_W-1:0]  p0_alt_reg, p0_alt_next;
    logic [DATA_W-1:0] p0_base_reg;

    logic [DIFF_W-1:0] abs_a, abs_b;
    logic [DIV_W-1:0]  sum_ab;
    logic [MAG_W-1:0]  mc_half, minab;
    logic [MAG_W:0]    two_min;

    always_comb begin
        p0_neg_next  = slope_a[DIFF_W-1];
        p0_zero_next = (slope_a == '0) || (slope_b == '0)
                       || (slope_a[DIFF_W-1] != slope_b[DIFF_W-1]);
        abs_a = p0_neg_next ? DIFF_W'(-slope_a) : slope_a;
        abs_b = p0_neg_next ? DIFF_W'(-slope_b) : slope_b;
        p0_ma_next = abs_a[MAG_W-1:0];
        p0_mb_next = abs_b[MAG_W-1:0];
        minab   = (p0_ma_next < p0_mb_next) ? p0_ma_next : p0_mb_next;
        sum_ab  = {1'b0, p0_ma_next} + {1'b0, p0_mb_next};
        mc_half = sum_ab[DIV_W-1:1];
        two_min = {minab, 1'b0};
        if (mode == LIM_MC) begin
            p0_alt_next = ({1'b0, mc_half} < two_min) ? mc_half : two_min[MAG_W-1:0];
        end else begin
            p0_alt_next = minab;
        end
        p0_valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else if (en) begin
            p0_valid_reg <= p0_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_zero_reg <= p0_zero_next;
            p0_neg_reg  <= p0_neg_next;
            p0_ma_reg   <= p0_ma_next;
            p0_mb_reg   <= p0_mb_next;
            p0_alt_reg  <= p0_alt_next;
            p0_base_reg <= base;
        end
    end

    // ---- stage P1: A*B and A+B, load divider ----
    div_t             p1_reg, p1_next;
    logic [PROD_W-1:0] prod;

    always_comb begin
        prod         = {{MAG_W{1'b0}}, p0_ma_reg} * {{MAG_W{1'b0}}, p0_mb_reg};
        p1_next.valid = p0_valid_reg;
        p1_next.zero  = p0_zero_reg;
        p1_next.neg   = p0_neg_reg;
        p1_next.alt   = p0_alt_reg;
        p1_next.base  = p0_base_reg;
        // dividend 2*A*B: top bits seed the remainder, the rest shift in
        p1_next.rem   = {1'b0, prod[PROD_W-1:MAG_W]};
        p1_next.low   = {prod[MAG_W-1:0], 1'b0};
        p1_next.quo   = '0;
        p1_next.dvs   = {1'b0, p0_ma_reg} + {1'b0, p0_mb_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= '0;
        end else if (en) begin
            p1_reg <= p1_next;
        end
    end

    // ---- divider chain, one quotient bit per stage ----
    div_t chain [DIV_W+1];
    logic [DIV_W-1:0] vld_reg, vld_next;

    assign chain[0] = p1_reg;

    for (genvar k = 0; k < DIV_W; k++) begin : g_div
        mlr_div_step u_step (
            .aclk  (aclk),
            .en    (en),
            .d_in  (chain[k]),
            .d_out (chain[k+1])
        );
    end

    // valid bits ride a resettable shift line beside the chain
    always_comb begin
        vld_next = {vld_reg[DIV_W-2:0], p1_reg.valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // ---- final stage: pick magnitude, half slope, saturate ----
    div_t              dv;
    logic              fin_valid_reg;
    logic [DATA_W-1:0] fin_face_reg, fin_face_next;
    logic [DIV_W-1:0]  mag;
    logic [MAG_W-1:0]  half;
    logic [DATA_W+1:0] acc;

    always_comb begin
        dv   = chain[DIV_W];
        mag  = (mode == LIM_VANLEER) ? dv.quo : {1'b0, dv.alt};
        half = dv.zero ? '0 : mag[DIV_W-1:1];
        if (dv.neg ^ negate) begin
            acc = {{2{dv.base[DATA_W-1]}}, dv.base} - {2'b00, half};
        end else begin
            acc = {{2{dv.base[DATA_W-1]}}, dv.base} + {2'b00, half};
        end
        if (acc[DATA_W+1] && !(acc[DATA_W] && acc[DATA_W-1])) begin
            fin_face_next = {1'b1, {(DATA_W-1){1'b0}}};
        end else if (!acc[DATA_W+1] && (acc[DATA_W] || acc[DATA_W-1])) begin
            fin_face_next = {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            fin_face_next = acc[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= vld_reg[DIV_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_face_reg <= fin_face_next;
        end
    end

    assign out_valid = fin_valid_reg;
    assign face      = fin_face_reg;

    // chain valid copy and the resettable line must agree once out of reset
    a_chain_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn, DIV_W + 2) |-> (dv.valid == vld_reg[DIV_W-1]))
        else $error("divider chain valid out of step");
    a_zero_slope: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_reg[DIV_W-1] && dv.zero) |=> (face == $past(dv.base)))
        else $error("zero limited slope changed the base value");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(face) && $stable(out_valid))
        else $error("final stage moved while stalled");
endmodule
`default_nettype wire

@@ sv/muscl_limited_reconstruction.sv @@
// Top level: MUSCL face reconstruction with selectable slope limiter, stream in and out.
//
// Takes one four-cell stencil (cells i-1, i, i+1, i+2, signed Q16.16) per beat and returns
// the limited left and right states at face i+1/2, saturated to Q16.16. The limiter is set
// by the limiter_mode register: 0 minmod, 1 van Leer, 2 monotonized central (3 acts as
// minmod); write it only while no beats are in flight. The pipeline accepts one beat per
// clock while not frozen and is built from one difference stage, one magnitude stage,
// one 32x32 multiply stage, 33 restoring-division stages (one quotient bit each, for the
// van Leer 2ab/(a+b) term) and the output register. All limiter modes take the same path,
// so results leave in input order. The whole pipeline advances together and freezes while
// a finished beat sits in the output register with m_tready low; nothing is dropped.
`default_nettype none
module muscl_limited_reconstruction (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // limiter_mode write
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_wr_data,
    // stencil in
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [31:0] value_prev, [63:32] value_here, [95:64] value_next, [127:96] value_next2
    input  wire logic [127:0]  s_tdata,
    // faces out
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [31:0] face_left, [63:32] face_right
    output logic [63:0]        m_tdata
);
    import mlr_pkg::*;

    logic [MODE_W-1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= LIM_MINMOD;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // global advance: output register empty or being drained
    logic en;
    logic out_valid_l, out_valid_r;
    assign en       = !out_valid_l || m_tready;
    assign s_tready = en;

    // ---- stage A: cell differences ----
    logic signed [DATA_W-1:0] vm, v0, vp, vp2;
    assign vm  = s_tdata[DATA_W-1:0];
    assign v0  = s_tdata[2*DATA_W-1:DATA_W];
    assign vp  = s_tdata[3*DATA_W-1:2*DATA_W];
    assign vp2 = s_tdata[4*DATA_W-1:3*DATA_W];

    logic              a_valid_reg;
    logic [DIFF_W-1:0] d0_reg, d1_reg, d2_reg;
    logic [DIFF_W-1:0] d0_next, d1_next, d2_next;
    logic [DATA_W-1:0] v0_reg, vp_reg;

    always_comb begin
        d0_next = DIFF_W'(signed'({v0[DATA_W-1], v0}) - signed'({vm[DATA_W-1], vm}));
        d1_next = DIFF_W'(signed'({vp[DATA_W-1], vp}) - signed'({v0[DATA_W-1], v0}));
        d2_next = DIFF_W'(signed'({vp2[DATA_W-1], vp2}) - signed'({vp[DATA_W-1], vp}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg <= d0_next;
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            v0_reg <= v0;
            vp_reg <= vp;
        end
    end

    // ---- the two limited slopes ----
    logic [DATA_W-1:0] face_l, face_r;

    // left state: v(i) + s0/2
    mlr_slope_unit u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .mode      (mode_reg),
        .negate    (1'b0),
        .in_valid  (a_valid_reg),
        .slope_a   (d0_reg),
        .slope_b   (d1_reg),
        .base      (v0_reg),
        .out_valid (out_valid_l),
        .face      (face_l)
    );

    // right state: v(i+1) - s1/2
    mlr_slope_unit u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .mode      (mode_reg),
        .negate    (1'b1),
        .in_valid  (a_valid_reg),
        .slope_a   (d1_reg),
        .slope_b   (d2_reg),
        .base      (vp_reg),
        .out_valid (out_valid_r),
        .face      (face_r)
    );

    assign m_tvalid = out_valid_l;
    assign m_tdata  = {face_r, face_l};

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_l == out_valid_r)
        else $error("left and right slope lanes out of step");
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output drain");
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire
